// ===== src/bdpr_pkg.sv =====
// Shared types and constants for the bounded deque with positional remove.
// Holds command and status codes, field widths and the item struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bdpr_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int VALUE_W = 32;
  localparam int POS_W   = 4;
  localparam int COUNT_W = 5;

  typedef enum logic [1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_BACK  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_REMOVE_AT  = 2'd3
  } cmd_code_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef struct packed {
    cmd_code_t          command;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   position;
  } item_t;

endpackage

`default_nettype wire

// ===== src/bdpr_in_if.sv =====
// Command channel: valid/ready handshake carrying one command item.
// Depends on bdpr_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bdpr_in_if;
  logic                        valid;
  logic                        ready;
  bdpr_pkg::cmd_code_t         command;
  logic [bdpr_pkg::VALUE_W-1:0] value;
  logic [bdpr_pkg::POS_W-1:0]   position;

  modport source (output valid, command, value, position, input ready);
  modport sink   (input valid, command, value, position, output ready);
endinterface

`default_nettype wire

// ===== src/bdpr_out_if.sv =====
// Result channel: valid/ready handshake carrying removed value, status, count.
// Depends on bdpr_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bdpr_out_if;
  logic                         valid;
  logic                         ready;
  logic [bdpr_pkg::VALUE_W-1:0] removed_value;
  bdpr_pkg::status_t            status;
  logic [bdpr_pkg::COUNT_W-1:0] count;

  modport source (output valid, removed_value, status, count, input ready);
  modport sink   (input valid, removed_value, status, count, output ready);
endinterface

`default_nettype wire

// ===== src/bdpr_in_stage.sv =====
// Input register: captures one command item per cycle from the command channel while the core takes the held item.
// Depends on bdpr_pkg and bdpr_in_if.
`timescale 1ns / 1ps
`default_nettype none

module bdpr_in_stage (
  input  wire logic            clk,
  input  wire logic            rst_n,
  bdpr_in_if.sink              in_ch,
  output bdpr_pkg::item_t      dn_item,
  output logic                 dn_valid,
  input  wire logic            dn_ready
);

  logic            vld_r;
  bdpr_pkg::item_t item_r;

  // Take a new item when empty or when the held one moves on this cycle.
  assign in_ch.ready = !vld_r || dn_ready;
  assign dn_valid    = vld_r;
  assign dn_item     = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.command  <= in_ch.command;
      item_r.value    <= in_ch.value;
      item_r.position <= in_ch.position;
    end
  end

endmodule

`default_nettype wire

// ===== src/bdpr_core.sv =====
// Entry store, count and result register. Every command updates all entries
// in parallel in one pass. Depends on bdpr_pkg and bdpr_out_if.
`timescale 1ns / 1ps
`default_nettype none

module bdpr_core #(
  parameter int CAPACITY   = bdpr_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = bdpr_pkg::DATA_WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire bdpr_pkg::item_t  up_item,
  input  wire logic             up_valid,
  output logic                  up_ready,
  bdpr_out_if.source            out_ch
);

  localparam int HW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int CW = (HW > bdpr_pkg::POS_W) ? HW : bdpr_pkg::POS_W;

  logic [DATA_WIDTH-1:0] ent_r   [CAPACITY];
  logic [DATA_WIDTH-1:0] ent_nxt [CAPACITY];
  logic [HW-1:0]         held_r;
  logic [HW-1:0]         held_nxt;

  logic                          out_valid_r;
  logic [bdpr_pkg::VALUE_W-1:0]  removed_r;
  bdpr_pkg::status_t             status_r;
  logic [bdpr_pkg::COUNT_W-1:0]  count_r;

  logic                  acc;
  logic                  full;
  logic                  empty;
  logic                  pos_bad;
  logic [CW-1:0]         pos_ext;
  logic [IW-1:0]         take_idx;
  logic [DATA_WIDTH-1:0] val_d;
  logic [DATA_WIDTH-1:0] removed_d;
  logic                  do_pf;
  logic                  do_pb;
  logic                  do_take;
  bdpr_pkg::status_t     status_d;

  assign up_ready = !out_valid_r || out_ch.ready;
  assign acc      = up_valid && up_ready;

  assign val_d   = DATA_WIDTH'(up_item.value);
  assign pos_ext = CW'(up_item.position);
  assign full    = (held_r == HW'(CAPACITY));
  assign empty   = (held_r == '0);
  assign pos_bad = (pos_ext >= CW'(held_r));

  always_comb begin
    do_pf    = 1'b0;
    do_pb    = 1'b0;
    do_take  = 1'b0;
    status_d = bdpr_pkg::ST_OK;
    take_idx = IW'(pos_ext);
    case (up_item.command)
      bdpr_pkg::CMD_PUSH_FRONT: begin
        if (full) status_d = bdpr_pkg::ST_FULL;
        else      do_pf    = 1'b1;
      end
      bdpr_pkg::CMD_PUSH_BACK: begin
        if (full) status_d = bdpr_pkg::ST_FULL;
        else      do_pb    = 1'b1;
      end
      bdpr_pkg::CMD_POP_FRONT: begin
        take_idx = '0;
        if (empty) status_d = bdpr_pkg::ST_EMPTY;
        else       do_take  = 1'b1;
      end
      bdpr_pkg::CMD_REMOVE_AT: begin
        if (pos_bad) status_d = bdpr_pkg::ST_RANGE;
        else         do_take  = 1'b1;
      end
      default: begin
        status_d = bdpr_pkg::ST_OK;
      end
    endcase
  end

  always_comb begin
    held_nxt = held_r;
    if (do_pf || do_pb) held_nxt = held_r + HW'(1);
    else if (do_take)   held_nxt = held_r - HW'(1);
  end

  assign removed_d = do_take ? ent_r[take_idx] : '0;

  // Each entry picks from itself or a neighbor; the gap after a remove closes.
  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_ent
    logic [DATA_WIDTH-1:0] prev_w;
    logic [DATA_WIDTH-1:0] next_w;

    if (gi == 0) begin : g_first
      assign prev_w = val_d;
    end else begin : g_mid
      assign prev_w = ent_r[gi-1];
    end

    if (gi == CAPACITY - 1) begin : g_last
      assign next_w = ent_r[gi];
    end else begin : g_rest
      assign next_w = ent_r[gi+1];
    end

    always_comb begin
      ent_nxt[gi] = ent_r[gi];
      if (do_pf) begin
        ent_nxt[gi] = prev_w;
      end else if (do_pb && (HW'(gi) == held_r)) begin
        ent_nxt[gi] = val_d;
      end else if (do_take && (IW'(gi) >= take_idx)) begin
        ent_nxt[gi] = next_w;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      ent_r <= ent_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else if (acc) begin
      held_r      <= held_nxt;
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      removed_r <= bdpr_pkg::VALUE_W'(removed_d);
      status_r  <= status_d;
      count_r   <= bdpr_pkg::COUNT_W'(held_nxt);
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.removed_value = removed_r;
  assign out_ch.status        = status_r;
  assign out_ch.count         = count_r;

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= HW'(CAPACITY))
    else $error("entry count above capacity");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r && $stable(held_r))
    else $error("store changed while result stalled");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r == bdpr_pkg::ST_FULL)
      |-> count_r == bdpr_pkg::COUNT_W'(CAPACITY))
    else $error("full status with count below capacity");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r == bdpr_pkg::ST_EMPTY) |-> count_r == '0)
    else $error("underflow status with nonzero count");

  a_take_dec: assert property (@(posedge clk) disable iff (!rst_n)
    acc && do_take |=> held_r == $past(held_r) - HW'(1))
    else $error("remove did not drop the count by one");

endmodule

`default_nettype wire

// ===== src/bounded_deque_positional_remove.sv =====
// Bounded deque with front/back insert, front remove and positional remove.
// Pipeline: an accepted command passes the input reg, then the result reg.
// Throughput: one command per cycle if not stalled; all entries shift in one pass.
// Reset: rst_n synchronous, active low; clears count and valid flags only.
// Entry contents are not cleared and are read only below the count.
// Depends on bdpr_pkg, bdpr_in_if, bdpr_out_if, bdpr_in_stage, bdpr_core.
`timescale 1ns / 1ps
`default_nettype none

module bounded_deque_positional_remove #(
  parameter int CAPACITY   = bdpr_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = bdpr_pkg::DATA_WIDTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  bdpr_in_if.sink    in_ch,
  bdpr_out_if.source out_ch
);

  bdpr_pkg::item_t item_w;
  logic            item_valid;
  logic            item_ready;

  bdpr_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .dn_item  (item_w),
    .dn_valid (item_valid),
    .dn_ready (item_ready)
  );

  bdpr_core #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_item  (item_w),
    .up_valid (item_valid),
    .up_ready (item_ready),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

// ===== tb/bounded_deque_positional_remove_tb.sv =====
// Testbench for the bounded deque with front/back insert and positional remove.
// Drives commands through bdpr_in_if, checks results from bdpr_out_if against a
// shadow copy of the deque held in a scoreboard class. Depends on bdpr_pkg and the RTL.
`timescale 1ns / 1ps

module bounded_deque_positional_remove_tb;

  localparam int DEPTH      = bdpr_pkg::CAPACITY_DEF;
  localparam int CYCLE_CAP  = 400000;
  localparam int DRAIN_WAIT = 8;

  // Shadow of the deque contents; predicts one outcome per accepted command.
  class deque_shadow;
    typedef struct {
      logic [bdpr_pkg::VALUE_W-1:0] removed;
      bdpr_pkg::status_t            status;
      logic [bdpr_pkg::COUNT_W-1:0] count;
    } outcome_t;

    logic [bdpr_pkg::VALUE_W-1:0] slots [DEPTH];
    int                           held;
    int                           failures;
    outcome_t                     expected_outcomes [$];

    function new();
      held     = 0;
      failures = 0;
    endfunction

    function logic [bdpr_pkg::VALUE_W-1:0] take_at(int idx);
      logic [bdpr_pkg::VALUE_W-1:0] v;
      v = slots[idx];
      for (int i = idx; i + 1 < held; i++) slots[i] = slots[i + 1];
      held--;
      return v;
    endfunction

    function void note_command(bdpr_pkg::cmd_code_t cmd,
                               logic [bdpr_pkg::VALUE_W-1:0] val,
                               logic [bdpr_pkg::POS_W-1:0] pos);
      outcome_t o;
      o.removed = '0;
      o.status  = bdpr_pkg::ST_OK;
      case (cmd)
        bdpr_pkg::CMD_PUSH_FRONT: begin
          if (held >= DEPTH) begin
            o.status = bdpr_pkg::ST_FULL;
          end else begin
            for (int i = held; i > 0; i--) slots[i] = slots[i - 1];
            slots[0] = val;
            held++;
          end
        end
        bdpr_pkg::CMD_PUSH_BACK: begin
          if (held >= DEPTH) begin
            o.status = bdpr_pkg::ST_FULL;
          end else begin
            slots[held] = val;
            held++;
          end
        end
        bdpr_pkg::CMD_POP_FRONT: begin
          if (held == 0) o.status = bdpr_pkg::ST_EMPTY;
          else o.removed = take_at(0);
        end
        default: begin
          if (int'(pos) >= held) o.status = bdpr_pkg::ST_RANGE;
          else o.removed = take_at(int'(pos));
        end
      endcase
      o.count = held[bdpr_pkg::COUNT_W-1:0];
      expected_outcomes.push_back(o);
    endfunction

    function void check_result(logic [bdpr_pkg::VALUE_W-1:0] removed,
                               bdpr_pkg::status_t st,
                               logic [bdpr_pkg::COUNT_W-1:0] cnt);
      outcome_t o;
      if (expected_outcomes.size() == 0) begin
        $display("%0t: result with nothing expected: removed %h status %0d count %0d",
                 $time, removed, st, cnt);
        failures++;
        return;
      end
      o = expected_outcomes.pop_front();
      if (removed !== o.removed) begin
        $display("%0t: removed_value mismatch: expected %h actual %h",
                 $time, o.removed, removed);
        failures++;
      end
      if (st !== o.status) begin
        $display("%0t: status mismatch: expected %0d actual %0d", $time, o.status, st);
        failures++;
      end
      if (cnt !== o.count) begin
        $display("%0t: count mismatch: expected %0d actual %0d", $time, o.count, cnt);
        failures++;
      end
    endfunction

    function int pending();
      return expected_outcomes.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  bdpr_in_if  in_ch ();
  bdpr_out_if out_ch ();

  bounded_deque_positional_remove dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  deque_shadow shadow;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_left;
  int          cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.command  = bdpr_pkg::CMD_PUSH_FRONT;
    in_ch.value    = '0;
    in_ch.position = '0;
    out_ch.ready   = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    cycles         = 0;
    shadow         = new();
  end

  // Run limit.
  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_CAP) begin
        $display("bounded_deque_positional_remove_tb: FAIL");
        $finish;
      end
    end
  end

  // Receiver: long hold-off when requested, random stalls otherwise.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Result checker.
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        shadow.check_result(out_ch.removed_value, out_ch.status, out_ch.count);
    end
  end

  task automatic send_command(input bdpr_pkg::cmd_code_t cmd,
                              input logic [bdpr_pkg::VALUE_W-1:0] val,
                              input logic [bdpr_pkg::POS_W-1:0] pos);
    int gap;
    gap = 0;
    while (gap < 16 && $urandom_range(99) < send_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.command  <= cmd;
    in_ch.value    <= val;
    in_ch.position <= pos;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    shadow.note_command(cmd, val, pos);
  endtask

  // Drop valid and hold until every outstanding result is back.
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (shadow.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [bdpr_pkg::VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  // Bias toward inserts by insert_pct; removals mostly hit a held position.
  task automatic send_random(input int insert_pct);
    bdpr_pkg::cmd_code_t        cmd;
    logic [bdpr_pkg::POS_W-1:0] pos;
    pos = bdpr_pkg::POS_W'($urandom_range(15));
    if ($urandom_range(99) < insert_pct) begin
      cmd = $urandom_range(1) ? bdpr_pkg::CMD_PUSH_BACK : bdpr_pkg::CMD_PUSH_FRONT;
    end else if ($urandom_range(1)) begin
      cmd = bdpr_pkg::CMD_POP_FRONT;
    end else begin
      cmd = bdpr_pkg::CMD_REMOVE_AT;
      if (shadow.held > 0 && $urandom_range(9) < 8)
        pos = bdpr_pkg::POS_W'($urandom_range(shadow.held - 1));
    end
    send_command(cmd, pick_value(), pos);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int n_items);
    int bias [5];
    bias = '{80, 20, 50, 95, 5};
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n_items; i++) send_random(bias[(i / 40) % 5]);
    drain_results();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty-store errors, last-position remove, fill, full inserts.
    send_command(bdpr_pkg::CMD_POP_FRONT, $urandom, 4'd0);
    send_command(bdpr_pkg::CMD_REMOVE_AT, $urandom, 4'd0);
    send_command(bdpr_pkg::CMD_PUSH_BACK, '0, 4'd15);
    send_command(bdpr_pkg::CMD_REMOVE_AT, $urandom, 4'd1);
    send_command(bdpr_pkg::CMD_REMOVE_AT, $urandom, 4'd0);
    for (int i = 0; i < DEPTH; i++) begin
      send_command((i % 2) ? bdpr_pkg::CMD_PUSH_BACK : bdpr_pkg::CMD_PUSH_FRONT,
                   (i == 0) ? '1 : ((i == 1) ? '0 : $urandom), bdpr_pkg::POS_W'(i));
    end
    send_command(bdpr_pkg::CMD_PUSH_FRONT, $urandom, 4'd0);
    send_command(bdpr_pkg::CMD_PUSH_BACK, $urandom, 4'd15);
    send_command(bdpr_pkg::CMD_REMOVE_AT, $urandom, 4'd15);
    send_command(bdpr_pkg::CMD_REMOVE_AT, $urandom, 4'd15);
    send_command(bdpr_pkg::CMD_POP_FRONT, $urandom, 4'd7);
    drain_results();

    // Hold off the receiver while commands keep coming, so the input stalls.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 80;
    for (int i = 0; i < 40; i++) send_random(60);
    drain_results();

    run_phase(0, 0, 380);
    run_phase(58, 0, 370);
    run_phase(0, 58, 370);
    run_phase(35, 35, 370);

    repeat (DRAIN_WAIT) @(posedge clk);
    if (shadow.failures == 0 && shadow.pending() == 0) begin
      $display("bounded_deque_positional_remove_tb: PASS");
    end else begin
      $display("bounded_deque_positional_remove_tb: FAIL");
    end
    $finish;
  end

endmodule
